/* src/cpc_pkg.sv */
// Types and constants shared by the circle pair contact pipeline.
package cpc_pkg;

    localparam int SqrtSteps = 31;
    localparam int DivSteps  = 15;

    localparam logic [0:0] AddrMinDist = 1'b0;

    typedef struct packed {
        logic [15:0] pair_tag;
        logic [31:0] first_x;
        logic [31:0] first_y;
        logic [29:0] first_radius;
        logic [31:0] second_x;
        logic [31:0] second_y;
        logic [29:0] second_radius;
    } t_in;

    typedef struct packed {
        logic [15:0] tag_out;
        logic        hit;
        logic [15:0] normal_x;
        logic [15:0] normal_y;
        logic [30:0] penetration;
        logic [31:0] contact_x;
        logic [31:0] contact_y;
    } t_res;

    // Side data carried along the root chain
    typedef struct packed {
        logic [15:0] tag;
        logic [31:0] ax;
        logic [31:0] ay;
        logic [29:0] r1;
        logic [30:0] rs;
        logic        sx;
        logic        sy;
        logic [30:0] adx;
        logic [30:0] ady;
        logic        miss;
    } t_sq_pay;

    typedef struct packed {
        logic        valid;
        t_sq_pay     pay;
        logic [61:0] rad;
        logic [31:0] rem;
        logic [30:0] root;
    } t_sq;

    // Side data carried along the divider chain
    typedef struct packed {
        logic [15:0] tag;
        logic [31:0] ax;
        logic [31:0] ay;
        logic [29:0] r1;
        logic [30:0] pen;
        logic        sx;
        logic        sy;
        logic        miss;
    } t_dv_pay;

    typedef struct packed {
        logic        valid;
        t_dv_pay     pay;
        logic [44:0] dsr;
        logic [45:0] remx;
        logic [45:0] remy;
        logic [14:0] qx;
        logic [14:0] qy;
    } t_dv;

endpackage

/* src/cpc_sqrt_cell.sv */
// One digit step of the integer square root chain.
module cpc_sqrt_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cpc_pkg::t_sq  i_sq,
    output cpc_pkg::t_sq  o_sq
);

    cpc_pkg::t_sq r_sq;
    cpc_pkg::t_sq n_sq;
    logic [33:0]  rem_s;
    logic [33:0]  trial;
    logic         ge;

    always_comb begin
        rem_s = {i_sq.rem, i_sq.rad[61:60]};
        trial = {1'b0, i_sq.root, 2'b01};
        ge    = rem_s >= trial;
        n_sq       = i_sq;
        n_sq.rad   = {i_sq.rad[59:0], 2'b00};
        n_sq.rem   = ge ? 32'(rem_s - trial) : rem_s[31:0];
        n_sq.root  = {i_sq.root[29:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq <= '0;
        end else begin
            r_sq <= n_sq;
        end
    end

    assign o_sq = r_sq;

endmodule

/* src/cpc_div_cell.sv */
// One quotient bit step of the two normal dividers.
module cpc_div_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cpc_pkg::t_dv  i_dv,
    output cpc_pkg::t_dv  o_dv
);

    cpc_pkg::t_dv r_dv;
    cpc_pkg::t_dv n_dv;
    logic         ge_x;
    logic         ge_y;

    always_comb begin
        ge_x = i_dv.remx >= {1'b0, i_dv.dsr};
        ge_y = i_dv.remy >= {1'b0, i_dv.dsr};
        n_dv      = i_dv;
        n_dv.remx = ge_x ? i_dv.remx - {1'b0, i_dv.dsr} : i_dv.remx;
        n_dv.remy = ge_y ? i_dv.remy - {1'b0, i_dv.dsr} : i_dv.remy;
        n_dv.qx   = {i_dv.qx[13:0], ge_x};
        n_dv.qy   = {i_dv.qy[13:0], ge_y};
        n_dv.dsr  = i_dv.dsr >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= '0;
        end else begin
            r_dv <= n_dv;
        end
    end

    assign o_dv = r_dv;

endmodule

/* src/circle_pair_contact.sv */
// Circle pair contact: a new pair is taken every cycle (busy stays low) and its result
// appears for one cycle on o_done once it has passed every stage. The pipeline is the 31-cell
// square root chain and the 15-cell normal divider chain plus seven arithmetic stages.
// The receiver cannot stall; results must be taken on the cycle they are shown.
module circle_pair_contact (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  cpc_pkg::t_in   i_item,
    output logic           o_done,
    output cpc_pkg::t_res  o_res,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [0:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    logic [15:0] r_min_dist;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign prdata = (paddr == cpc_pkg::AddrMinDist) ? {16'b0, r_min_dist} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dist <= 16'd7;
        end else if (psel && penable && pwrite && paddr == cpc_pkg::AddrMinDist) begin
            r_min_dist <= pwdata[15:0];
        end
    end

    // Stage A: deltas, radius sum, axis gap test
    logic            r_a_valid;
    cpc_pkg::t_sq_pay r_a;
    cpc_pkg::t_sq_pay n_a;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [32:0]     adx_w;
    logic [32:0]     ady_w;

    always_comb begin
        dx    = $signed({i_item.second_x[31], i_item.second_x})
              - $signed({i_item.first_x[31], i_item.first_x});
        dy    = $signed({i_item.second_y[31], i_item.second_y})
              - $signed({i_item.first_y[31], i_item.first_y});
        adx_w = dx[32] ? 33'(-dx) : 33'(dx);
        ady_w = dy[32] ? 33'(-dy) : 33'(dy);
        n_a.tag  = i_item.pair_tag;
        n_a.ax   = i_item.first_x;
        n_a.ay   = i_item.first_y;
        n_a.r1   = i_item.first_radius;
        n_a.rs   = {1'b0, i_item.first_radius} + {1'b0, i_item.second_radius};
        n_a.sx   = dx[32];
        n_a.sy   = dy[32];
        n_a.adx  = adx_w[30:0];
        n_a.ady  = ady_w[30:0];
        n_a.miss = (adx_w >= {2'b0, n_a.rs}) || (ady_w >= {2'b0, n_a.rs});
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= start;
        end
    end

    // Stage B: squares
    logic             r_b_valid;
    cpc_pkg::t_sq_pay r_b;
    logic [61:0]      r_sqx;
    logic [61:0]      r_sqy;
    logic [61:0]      r_rs2;

    always_ff @(posedge i_clk) begin
        r_b   <= r_a;
        r_sqx <= r_a.adx * r_a.adx;
        r_sqy <= r_a.ady * r_a.ady;
        r_rs2 <= r_a.rs * r_a.rs;
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
    end

    // Stage C: squared distance against squared radius sum
    cpc_pkg::t_sq r_c;
    cpc_pkg::t_sq n_c;
    logic [62:0]  dsq;

    always_comb begin
        dsq        = {1'b0, r_sqx} + {1'b0, r_sqy};
        n_c.valid  = r_b_valid;
        n_c.pay    = r_b;
        n_c.pay.miss = r_b.miss || (dsq >= {1'b0, r_rs2});
        n_c.rad    = dsq[61:0];
        n_c.rem    = '0;
        n_c.root   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c <= '0;
        end else begin
            r_c <= n_c;
        end
    end

    // Square root chain
    cpc_pkg::t_sq sq_link [cpc_pkg::SqrtSteps+1];
    assign sq_link[0] = r_c;

    for (genvar g = 0; g < cpc_pkg::SqrtSteps; g++) begin : g_sqrt
        cpc_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_sq    (sq_link[g]),
            .o_sq    (sq_link[g+1])
        );
    end

    // Stage D: minimum distance, penetration, divider setup
    cpc_pkg::t_sq sq_out;
    cpc_pkg::t_dv r_d;
    cpc_pkg::t_dv n_d;
    logic [30:0]  dist_q;

    assign sq_out = sq_link[cpc_pkg::SqrtSteps];

    always_comb begin
        dist_q       = sq_out.root;
        n_d.valid    = sq_out.valid;
        n_d.pay.tag  = sq_out.pay.tag;
        n_d.pay.ax   = sq_out.pay.ax;
        n_d.pay.ay   = sq_out.pay.ay;
        n_d.pay.r1   = sq_out.pay.r1;
        n_d.pay.pen  = sq_out.pay.rs - dist_q;
        n_d.pay.sx   = sq_out.pay.sx;
        n_d.pay.sy   = sq_out.pay.sy;
        n_d.pay.miss = sq_out.pay.miss || (dist_q == '0)
                    || (dist_q < {15'b0, r_min_dist});
        n_d.dsr      = {dist_q, 14'b0};
        n_d.remx     = {1'b0, sq_out.pay.adx, 14'b0} + {16'b0, dist_q[30:1]};
        n_d.remy     = {1'b0, sq_out.pay.ady, 14'b0} + {16'b0, dist_q[30:1]};
        n_d.qx       = '0;
        n_d.qy       = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d <= '0;
        end else begin
            r_d <= n_d;
        end
    end

    // Divider chain
    cpc_pkg::t_dv dv_link [cpc_pkg::DivSteps+1];
    assign dv_link[0] = r_d;

    for (genvar g = 0; g < cpc_pkg::DivSteps; g++) begin : g_div
        cpc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_dv    (dv_link[g]),
            .o_dv    (dv_link[g+1])
        );
    end

    // Stage E: signed normal and twice the offset length
    cpc_pkg::t_dv       dv_out;
    logic               r_e_valid;
    cpc_pkg::t_dv_pay   r_e;
    logic signed [15:0] r_nx;
    logic signed [15:0] r_ny;
    logic signed [32:0] r_s2;

    assign dv_out = dv_link[cpc_pkg::DivSteps];

    always_ff @(posedge i_clk) begin
        r_e  <= dv_out.pay;
        r_nx <= dv_out.pay.sx ? -$signed({1'b0, dv_out.qx}) : $signed({1'b0, dv_out.qx});
        r_ny <= dv_out.pay.sy ? -$signed({1'b0, dv_out.qy}) : $signed({1'b0, dv_out.qy});
        r_s2 <= $signed({2'b0, dv_out.pay.r1, 1'b0}) - $signed({2'b0, dv_out.pay.pen});
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else begin
            r_e_valid <= dv_out.valid;
        end
    end

    // Stage F: offset products
    logic               r_f_valid;
    cpc_pkg::t_dv_pay   r_f;
    logic signed [15:0] r_f_nx;
    logic signed [15:0] r_f_ny;
    logic signed [48:0] r_px;
    logic signed [48:0] r_py;

    always_ff @(posedge i_clk) begin
        r_f    <= r_e;
        r_f_nx <= r_nx;
        r_f_ny <= r_ny;
        r_px   <= 49'(r_nx * r_s2);
        r_py   <= 49'(r_ny * r_s2);
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else begin
            r_f_valid <= r_e_valid;
        end
    end

    // Stage G: round, add to first centre, saturate, zero on miss
    cpc_pkg::t_res      n_res;
    logic [47:0]        mag_x;
    logic [47:0]        mag_y;
    logic [33:0]        off_mx;
    logic [33:0]        off_my;
    logic signed [35:0] sum_x;
    logic signed [35:0] sum_y;
    logic [31:0]        cx;
    logic [31:0]        cy;

    always_comb begin
        mag_x  = r_px[48] ? 48'(-r_px) : r_px[47:0];
        mag_y  = r_py[48] ? 48'(-r_py) : r_py[47:0];
        off_mx = 34'((({1'b0, mag_x} + 49'd16384) >> 15));
        off_my = 34'((({1'b0, mag_y} + 49'd16384) >> 15));
        sum_x  = $signed({{4{r_f.ax[31]}}, r_f.ax})
               + (r_px[48] ? -$signed({2'b0, off_mx}) : $signed({2'b0, off_mx}));
        sum_y  = $signed({{4{r_f.ay[31]}}, r_f.ay})
               + (r_py[48] ? -$signed({2'b0, off_my}) : $signed({2'b0, off_my}));
        if (sum_x > 36'sd2147483647) begin
            cx = 32'h7FFF_FFFF;
        end else if (sum_x < -36'sd2147483648) begin
            cx = 32'h8000_0000;
        end else begin
            cx = sum_x[31:0];
        end
        if (sum_y > 36'sd2147483647) begin
            cy = 32'h7FFF_FFFF;
        end else if (sum_y < -36'sd2147483648) begin
            cy = 32'h8000_0000;
        end else begin
            cy = sum_y[31:0];
        end
        n_res.tag_out = r_f.tag;
        if (r_f.miss) begin
            n_res.hit         = 1'b0;
            n_res.normal_x    = '0;
            n_res.normal_y    = '0;
            n_res.penetration = '0;
            n_res.contact_x   = '0;
            n_res.contact_y   = '0;
        end else begin
            n_res.hit         = 1'b1;
            n_res.normal_x    = r_f_nx;
            n_res.normal_y    = r_f_ny;
            n_res.penetration = r_f.pen;
            n_res.contact_x   = cx;
            n_res.contact_y   = cy;
        end
    end

    always_ff @(posedge i_clk) begin
        o_res <= n_res;
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_f_valid;
        end
    end

`ifndef SYNTHESIS
    a_hit_pen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_res.hit |-> o_res.penetration != '0)
        else $error("hit with zero penetration");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_res.hit |-> o_res.normal_x == '0 && o_res.normal_y == '0
            && o_res.contact_x == '0 && o_res.contact_y == '0)
        else $error("miss with nonzero fields");

    a_unit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_res.hit |-> $signed(o_res.normal_x) <= 16'sd16384
            && $signed(o_res.normal_x) >= -16'sd16384)
        else $error("normal out of range");
`endif

endmodule

/* tb/tb.sv */
// Self-checking testbench for the circle pair contact pipeline.
module tb;

    localparam int PipeDepth   = 53;
    localparam int StallLimit  = 3000;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    cpc_pkg::t_in  i_item;
    logic          o_done;
    cpc_pkg::t_res o_res;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [0:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    logic [15:0]   min_dist_copy;
    cpc_pkg::t_res contact_queue[$];
    int            fail_count;
    int            quiet_cycles;

    circle_pair_contact dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_done  (o_done),
        .o_res   (o_res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Unit component in Q2.14, rounded half away from zero
    function automatic longint norm_q14(longint d, longint unsigned root_q);
        longint unsigned m;
        m = ((d < 0 ? -d : d) * 64'd16384 + root_q / 2) / root_q;
        return d < 0 ? -longint'(m) : longint'(m);
    endfunction

    // Centre plus normal times twice-offset, scaled down by 2^15 and clamped
    function automatic logic [31:0] shift_clamp(longint base, longint n, longint s2);
        longint p;
        longint unsigned m;
        longint v;
        p = n * s2;
        m = ((p < 0 ? -p : p) + 64'd16384) >> 15;
        v = base + (p < 0 ? -longint'(m) : longint'(m));
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic cpc_pkg::t_res predict_contact(cpc_pkg::t_in p, logic [15:0] md);
        cpc_pkg::t_res r;
        longint ax, ay, dx, dy, nx, ny, s2;
        longint unsigned rs, adx, ady, dsq, root_q, pen, rem, bit_w;
        r = '0;
        r.tag_out = p.pair_tag;
        ax = $signed(p.first_x);
        ay = $signed(p.first_y);
        dx = longint'($signed(p.second_x)) - ax;
        dy = longint'($signed(p.second_y)) - ay;
        rs = p.first_radius + p.second_radius;
        adx = dx < 0 ? -dx : dx;
        ady = dy < 0 ? -dy : dy;
        if (adx >= rs || ady >= rs) return r;
        dsq = adx * adx + ady * ady;
        if (dsq >= rs * rs) return r;
        // floor square root, digit by digit
        rem = dsq;
        root_q = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > rem) bit_w >>= 2;
        while (bit_w != 0) begin
            if (rem >= root_q + bit_w) begin
                rem -= root_q + bit_w;
                root_q = (root_q >> 1) + bit_w;
            end else begin
                root_q >>= 1;
            end
            bit_w >>= 2;
        end
        if (root_q == 0 || root_q < md) return r;
        nx = norm_q14(dx, root_q);
        ny = norm_q14(dy, root_q);
        pen = rs - root_q;
        s2 = longint'(2 * p.first_radius) - longint'(pen);
        r.hit = 1'b1;
        r.normal_x = nx[15:0];
        r.normal_y = ny[15:0];
        r.penetration = pen[30:0];
        r.contact_x = shift_clamp(ax, nx, s2);
        r.contact_y = shift_clamp(ay, ny, s2);
        return r;
    endfunction

    task automatic send_pair(cpc_pkg::t_in p);
        @(negedge i_clk);
        i_item <= p;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy);
        contact_queue.push_back(predict_contact(p, min_dist_copy));
    endtask

    // Send with a random gap after the transaction; start drops only when a gap follows
    task automatic send_paced(cpc_pkg::t_in p, ref int burst_left);
        int gap;
        send_pair(p);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge i_clk);
                start <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    task automatic drain;
        @(negedge i_clk);
        start <= 1'b0;
        while (contact_queue.size() != 0) @(posedge i_clk);
        repeat (PipeDepth + 5) @(posedge i_clk);
    endtask

    task automatic write_min_dist(logic [15:0] v);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= cpc_pkg::AddrMinDist; pwdata <= {16'h0, v};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        min_dist_copy = v;
        // read back
        @(negedge i_clk);
        psel <= 1'b1;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[15:0] !== v) begin
            $error("min_distance readback expected %0h got %0h", v, prdata);
            fail_count++;
        end
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0;
    endtask

    function automatic cpc_pkg::t_in make_pair(logic [31:0] ax, logic [31:0] ay,
                                               logic [29:0] r1, logic [31:0] bx,
                                               logic [31:0] by, logic [29:0] r2);
        cpc_pkg::t_in p;
        p.pair_tag = 16'($urandom);
        p.first_x = ax; p.first_y = ay; p.first_radius = r1;
        p.second_x = bx; p.second_y = by; p.second_radius = r2;
        return p;
    endfunction

    // Mostly overlapping pairs at a random scale, some full-range noise
    function automatic cpc_pkg::t_in random_pair;
        cpc_pkg::t_in p;
        logic [223:0] noise;
        int sh;
        longint dx, dy, span;
        if ($urandom_range(0, 9) < 2) begin
            noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            p = noise[$bits(cpc_pkg::t_in)-1:0];
            return p;
        end
        sh = $urandom_range(2, 28);
        span = longint'(1) << sh;
        dx = longint'($urandom_range(0, 2 * span)) - span;
        dy = longint'($urandom_range(0, 2 * span)) - span;
        p.pair_tag = 16'($urandom);
        case ($urandom_range(0, 5))
            0: p.first_x = 32'h7FFF_FFFF - $urandom_range(0, span);
            1: p.first_x = 32'h8000_0000 + $urandom_range(0, span);
            default: p.first_x = $urandom;
        endcase
        p.first_y = ($urandom_range(0, 5) == 0) ? 32'h8000_0000 + $urandom_range(0, span)
                                                : $urandom;
        p.second_x = p.first_x + dx[31:0];
        p.second_y = p.first_y + dy[31:0];
        p.first_radius  = 30'($urandom_range(0, 2 * span));
        p.second_radius = 30'($urandom_range(0, 2 * span));
        if ($urandom_range(0, 15) == 0) begin
            p.first_radius = 30'(30'h3FFF_FFFF - $urandom_range(0, 255));
        end
        return p;
    endfunction

    task automatic test_directed;
        // extremes, axis gap, touching, coincident, saturation both ways
        send_pair(make_pair(32'h0, 32'h0, 30'h10000, 32'h8000, 32'h0, 30'h10000));
        send_pair(make_pair(32'h0, 32'h0, 30'h10000, 32'h0, 32'hFFFF_8000, 30'h10000));
        send_pair(make_pair(32'h0, 32'h0, 30'h10000, 32'h20000, 32'h0, 30'h10000));
        send_pair(make_pair(32'h0, 32'h0, 30'h10000, 32'h30000, 32'h100, 30'h10000));
        send_pair(make_pair(32'h0, 32'h0, 30'h18000, 32'h18000, 32'h18000, 30'h8000));
        send_pair(make_pair(32'h1234, 32'h5678, 30'h10000, 32'h1234, 32'h5678, 30'h10000));
        send_pair(make_pair(32'h0, 32'h0, 30'h10000, 32'h6, 32'h0, 30'h10000));
        send_pair(make_pair(32'h0, 32'h0, 30'h10000, 32'h7, 32'h0, 30'h10000));
        send_pair(make_pair(32'h7FFF_F000, 32'h0, 30'h3FFF_FFFF, 32'h7FFF_FFFF, 32'h0,
                            30'h3FFF_FFFF));
        send_pair(make_pair(32'h8000_1000, 32'h8000_1000, 30'h3FFF_FFFF, 32'h8000_0000,
                            32'h8000_0000, 30'h3FFF_FFFF));
        send_pair(make_pair(32'h8000_0000, 32'h8000_0000, 30'h3FFF_FFFF, 32'h7FFF_FFFF,
                            32'h7FFF_FFFF, 30'h3FFF_FFFF));
        send_pair(make_pair(32'h0, 32'h0, 30'h0, 32'h1, 32'h1, 30'h0));
        send_pair(make_pair(32'h0, 32'h0, 30'h0, 32'h1, 32'h0, 30'h3FFF_FFFF));
        send_pair(make_pair(32'h4000_0000, 32'hC000_0000, 30'h2000_0000, 32'h4100_0000,
                            32'hC080_0000, 30'h1000_0000));
        send_pair(make_pair(32'hFFFF_FFFF, 32'h0, 30'h1, 32'h0, 32'h0, 30'h1));
        drain();
    endtask

    task automatic test_min_distance_edges(logic [15:0] md);
        write_min_dist(md);
        send_pair(make_pair(32'h0, 32'h0, 30'h20000, {16'h0, md} - 1, 32'h0, 30'h20000));
        send_pair(make_pair(32'h0, 32'h0, 30'h20000, {16'h0, md}, 32'h0, 30'h20000));
        send_pair(make_pair(32'h0, 32'h0, 30'h20000, 32'h0, {16'h0, md} + 1, 30'h20000));
        send_pair(make_pair(32'h100, 32'h100, 30'h1, 32'h100, 32'h100, 30'h1));
        drain();
    endtask

    task automatic test_random_run(logic [15:0] md, int count);
        int burst_left;
        burst_left = 0;
        write_min_dist(md);
        repeat (count) send_paced(random_pair(), burst_left);
        drain();
    endtask

    always @(posedge i_clk) begin
        cpc_pkg::t_res e;
        if (i_rst_n && o_done) begin
            if (contact_queue.size() == 0) begin
                $error("result with no pending pair, tag %0h", o_res.tag_out);
                fail_count++;
            end else begin
                e = contact_queue.pop_front();
                if (o_res.tag_out !== e.tag_out) begin
                    $error("tag_out expected %0h got %0h", e.tag_out, o_res.tag_out);
                    fail_count++;
                end
                if (o_res.hit !== e.hit) begin
                    $error("hit expected %0h got %0h", e.hit, o_res.hit);
                    fail_count++;
                end
                if (o_res.normal_x !== e.normal_x) begin
                    $error("normal_x expected %0h got %0h", e.normal_x, o_res.normal_x);
                    fail_count++;
                end
                if (o_res.normal_y !== e.normal_y) begin
                    $error("normal_y expected %0h got %0h", e.normal_y, o_res.normal_y);
                    fail_count++;
                end
                if (o_res.penetration !== e.penetration) begin
                    $error("penetration expected %0h got %0h", e.penetration,
                           o_res.penetration);
                    fail_count++;
                end
                if (o_res.contact_x !== e.contact_x) begin
                    $error("contact_x expected %0h got %0h", e.contact_x, o_res.contact_x);
                    fail_count++;
                end
                if (o_res.contact_y !== e.contact_y) begin
                    $error("contact_y expected %0h got %0h", e.contact_y, o_res.contact_y);
                    fail_count++;
                end
            end
        end
    end

    // Abort when no transaction moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= StallLimit) begin
            $display("[circle_pair_contact] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = cpc_pkg::AddrMinDist;
        pwdata = '0;
        fail_count = 0;
        quiet_cycles = 0;
        min_dist_copy = 16'd7;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_min_distance_edges(16'd0);
        test_min_distance_edges(16'hFFFF);
        test_random_run(16'd0, 250);
        test_random_run(16'hFFFF, 250);
        test_random_run(16'($urandom), 250);
        test_random_run(16'd7, 250);

        if (fail_count == 0) begin
            $display("[circle_pair_contact] OK");
        end else begin
            $display("[circle_pair_contact] ERROR");
        end
        $finish;
    end
endmodule
